// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cssc check failed");

// next-cycle implication, sampled on clk, off during reset
`define CSSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cssc check failed");

`endif

// ===== rtl/cssc_pkg.sv =====
`timescale 1ns / 1ps
package cssc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_CLOCK  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RPS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SENSE_LIMIT = 2'd2;

    localparam logic [23:0] TICK_CLOCK_RESET  = 24'd250000;
    localparam logic [15:0] MIN_RPS_RESET     = 16'd10;
    localparam logic [16:0] SENSE_LIMIT_RESET = 17'd65535;

    localparam logic [1:0] FUNC_TOOTH    = 2'd0;
    localparam logic [1:0] FUNC_OVERFLOW = 2'd1;
    localparam logic [1:0] FUNC_TABLE    = 2'd2;

    localparam logic [23:0] RPM_PER_RPS      = 24'd60;
    localparam logic [7:0]  NO_MATCH_ADVANCE = 8'hFF;

    localparam int DIVIDEND_W = 24;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] interval;
        logic [3:0]  slot;
        logic [15:0] table_rpm;
        logic [7:0]  table_value;
    } req_t;

    typedef struct packed {
        logic        fire;
        logic        spark_select;
        logic [23:0] rps;
        logic [15:0] rpm;
        logic [27:0] pwm_frequency;
        logic [7:0]  advance_value;
        logic        synced;
    } rsp_t;

endpackage

// ===== rtl/cssc_if.sv =====
`timescale 1ns / 1ps
interface cssc_req_if;
    logic               valid;
    logic               ready;
    cssc_pkg::req_t     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cssc_rsp_if;
    logic               valid;
    logic               ready;
    cssc_pkg::rsp_t     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cssc_div.sv =====
`timescale 1ns / 1ps
module cssc_div #(
    parameter int DIVISOR_W = 18
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [cssc_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0]                divisor,
    output logic                                done,
    output logic [cssc_pkg::DIVIDEND_W-1:0]     quotient
);
    import cssc_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                   busy_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DIVIDEND_W-1:0]  quo_reg;
    logic [DIVISOR_W-1:0]   rem_reg;
    logic [DIVISOR_W-1:0]   dsr_reg;
    logic                   done_reg;
    logic [DIVISOR_W:0]     trial;
    logic                   fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : trial[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/crank_sync_spark_scheduler.sv =====
`timescale 1ns / 1ps
// Crank-synchronous spark scheduler. Each req transaction carries one event:
// a tooth interval, a capture overflow or a timing-table write; each gives
// exactly one rsp transaction. One event is processed at a time. Overflows,
// table writes and teeth that are not schedule points go straight to the
// finish state. A sense tooth scans the interval ring memory. A schedule
// point scans the ring, runs the bit-serial divider on a nonzero interval
// sum and, when the spark fires, walks the timing table memory one entry a
// cycle. The user must write configuration through cfg_we, cfg_index,
// cfg_data only while the block is idle; the block itself does not enforce
// this.
module crank_sync_spark_scheduler #(
    parameter int TEETH             = 4,
    parameter int SENSE_REVOLUTIONS = 8,
    parameter int TABLE_SLOTS       = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    cssc_req_if.sink                            req,
    cssc_rsp_if.source                          rsp,
    input  logic                                cfg_we,
    input  logic [cssc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cssc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cssc_pkg::*;

    localparam int TW    = $clog2(TEETH);
    localparam int CW    = $clog2(TEETH + 1);
    localparam int SUM_W = 16 + $clog2(TEETH);
    localparam int SW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int SCW   = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_LOOKUP, ST_FIN} state_t;

    // configuration registers
    logic [23:0]            tick_reg;
    logic [15:0]            min_rps_reg;
    logic [16:0]            limit_reg;

    // crank state
    state_t                 state_reg;
    logic [TEETH-1:0]       ring_valid_reg;
    logic [TW-1:0]          pos_reg;
    logic [TW-1:0]          cur_reg;
    logic [7:0]             rev_reg;
    logic                   sync_reg;
    logic [TW-1:0]          ref_reg;
    logic [15:0]            last_rpm_reg;

    // scan bookkeeping
    logic                   sense_reg;
    logic [CW-1:0]          cnt_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [16:0]            best_reg;
    logic [TW-1:0]          best_idx_reg;
    logic                   best_hit_reg;
    logic [SCW-1:0]         tcnt_reg;
    logic [7:0]             prev_val_reg;
    logic                   div_start_reg;

    // result of the current transaction
    logic                   fire_reg;
    logic                   sel_reg;
    logic [23:0]            rps_reg;
    logic [27:0]            pwm_reg;
    logic [7:0]             adv_reg;

    // output stage
    logic                   rsp_valid_reg;
    rsp_t                   rsp_data_reg;

    // memories
    logic [15:0]            ring_mem [TEETH];
    logic [15:0]            ring_q;
    logic                   ring_qv;
    logic [23:0]            tab_mem [TABLE_SLOTS];
    logic [23:0]            tab_q;

    logic                   accept;
    logic                   ring_we;
    logic                   tab_we;
    logic [TW-1:0]          ring_ra;
    logic [SW-1:0]          tab_ra;
    logic [SW-1:0]          tab_wa;
    logic [15:0]            ring_d;
    logic [TW-1:0]          scan_idx;
    logic                   take;
    logic [TW-1:0]          fin_best_idx;
    logic                   fin_hit;
    logic [SUM_W-1:0]       sum_fin;
    logic [TW-1:0]          pos_inc;
    logic [TW:0]            second_raw;
    logic [TW-1:0]          second_pos;
    logic [7:0]             rev_inc;
    logic                   div_done;
    logic [23:0]            div_q;
    logic [23:0]            rpm_calc;
    logic [SW-1:0]          tab_idx;
    logic                   out_free;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign ring_we  = accept && (req.data.func == FUNC_TOOTH);
    assign tab_we   = accept && (req.data.func == FUNC_TABLE) &&
                      (32'(req.data.slot) < TABLE_SLOTS);
    assign tab_wa   = SW'(req.data.slot);
    assign ring_ra  = (32'(cnt_reg) < TEETH) ? cnt_reg[TW-1:0] : '0;
    assign tab_ra   = (32'(tcnt_reg) < TABLE_SLOTS) ? tcnt_reg[SW-1:0] : '0;

    // interval ring: one write port at accept, one sweep read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[pos_reg] <= req.data.interval;
        end
        ring_q <= ring_mem[ring_ra];
    end

    // timing table: {rpm bound, advance}
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_wa] <= {req.data.table_rpm, req.data.table_value};
        end
        tab_q <= tab_mem[tab_ra];
    end

    // entries never written since reset read as zero
    assign ring_d = ring_qv ? ring_q : 16'd0;

    // scan step: consumes the entry fetched in the previous cycle
    assign scan_idx     = TW'(cnt_reg - 1'b1);
    assign take         = sense_reg && ({1'b0, ring_d} < best_reg);
    assign fin_best_idx = take ? scan_idx : best_idx_reg;
    assign fin_hit      = best_hit_reg || take;
    assign sum_fin      = sum_reg + SUM_W'(ring_d);

    // tooth bookkeeping
    assign pos_inc    = (32'(pos_reg) == TEETH - 1) ? '0 : TW'(pos_reg + 1'b1);
    assign second_raw = {1'b0, ref_reg} + (TW + 1)'(2);
    assign second_pos = (32'(second_raw) >= TEETH) ? TW'(second_raw - (TW + 1)'(TEETH))
                                                   : second_raw[TW-1:0];
    assign rev_inc    = rev_reg + 8'd1;

    assign rpm_calc = div_q * RPM_PER_RPS;
    assign tab_idx  = SW'(tcnt_reg - 1'b1);
    assign out_free = !rsp_valid_reg || rsp.ready;

    cssc_div #(
        .DIVISOR_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (tick_reg),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= TICK_CLOCK_RESET;
            min_rps_reg    <= MIN_RPS_RESET;
            limit_reg      <= SENSE_LIMIT_RESET;
            state_reg      <= ST_IDLE;
            ring_valid_reg <= '0;
            ring_qv        <= 1'b0;
            pos_reg        <= '0;
            cur_reg        <= '0;
            rev_reg        <= '0;
            sync_reg       <= 1'b0;
            ref_reg        <= '0;
            last_rpm_reg   <= '0;
            sense_reg      <= 1'b0;
            cnt_reg        <= '0;
            sum_reg        <= '0;
            best_reg       <= '0;
            best_idx_reg   <= '0;
            best_hit_reg   <= 1'b0;
            tcnt_reg       <= '0;
            prev_val_reg   <= '0;
            div_start_reg  <= 1'b0;
            fire_reg       <= 1'b0;
            sel_reg        <= 1'b0;
            rps_reg        <= '0;
            pwm_reg        <= '0;
            adv_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            ring_qv       <= ring_valid_reg[ring_ra];

            // config must be written only while nothing is in flight; the block does not enforce it
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TICK_CLOCK:  tick_reg    <= cfg_data[23:0];
                    CFG_MIN_RPS:     min_rps_reg <= cfg_data[15:0];
                    CFG_SENSE_LIMIT: limit_reg   <= cfg_data[16:0];
                    default:         ;
                endcase
            end

            // result taken; the finish state refills the stage itself
            if (rsp.ready && state_reg != ST_FIN)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        fire_reg  <= 1'b0;
                        sel_reg   <= 1'b0;
                        rps_reg   <= '0;
                        pwm_reg   <= '0;
                        adv_reg   <= '0;
                        cnt_reg   <= '0;
                        sum_reg   <= '0;
                        best_reg  <= limit_reg;
                        best_hit_reg <= 1'b0;
                        state_reg <= ST_FIN;
                        case (req.data.func)
                            FUNC_TOOTH:
                            begin
                                ring_valid_reg[pos_reg] <= 1'b1;
                                cur_reg <= pos_reg;
                                pos_reg <= pos_inc;
                                if (sync_reg)
                                begin
                                    // schedule points: reference tooth and the tooth two after it
                                    if (pos_reg == ref_reg || pos_reg == second_pos)
                                    begin
                                        sense_reg <= 1'b0;
                                        state_reg <= ST_SCAN;
                                    end
                                end
                                else if (pos_inc == '0)
                                begin
                                    // a full revolution seen while unsynced
                                    if (rev_inc == 8'(SENSE_REVOLUTIONS))
                                    begin
                                        rev_reg   <= '0;
                                        sense_reg <= 1'b1;
                                        state_reg <= ST_SCAN;
                                    end
                                    else
                                    begin
                                        rev_reg <= rev_inc;
                                    end
                                end
                            end
                            FUNC_OVERFLOW:
                            begin
                                rev_reg  <= '0;
                                sync_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg != '0)
                    begin
                        sum_reg      <= sum_fin;
                        best_idx_reg <= fin_best_idx;
                        best_hit_reg <= fin_hit;
                        if (take)
                        begin
                            best_reg <= {1'b0, ring_d};
                        end
                    end
                    if (32'(cnt_reg) == TEETH)
                    begin
                        if (sense_reg)
                        begin
                            // shortest interval below the limit becomes reference
                            sync_reg <= 1'b1;
                            if (fin_hit)
                            begin
                                ref_reg <= fin_best_idx;
                            end
                            state_reg <= ST_FIN;
                        end
                        else if (sum_fin == '0)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV;
                        end
                    end
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        rps_reg      <= div_q;
                        last_rpm_reg <= rpm_calc[15:0];
                        sel_reg      <= (cur_reg == ref_reg);
                        tcnt_reg     <= '0;
                        if (div_q >= {8'd0, min_rps_reg})
                        begin
                            fire_reg  <= 1'b1;
                            pwm_reg   <= 28'({4'd0, div_q} * 28'(TEETH));
                            state_reg <= ST_LOOKUP;
                        end
                        else
                        begin
                            state_reg <= ST_FIN;
                        end
                    end
                end

                ST_LOOKUP:
                begin
                    // first entry whose successor bound lies above rpm
                    tcnt_reg <= tcnt_reg + 1'b1;
                    if (tcnt_reg != '0)
                    begin
                        prev_val_reg <= tab_q[7:0];
                        if (tab_idx != '0 && last_rpm_reg < tab_q[23:8])
                        begin
                            adv_reg   <= prev_val_reg;
                            state_reg <= ST_FIN;
                        end
                        else if (32'(tcnt_reg) == TABLE_SLOTS)
                        begin
                            adv_reg   <= NO_MATCH_ADVANCE;
                            state_reg <= ST_FIN;
                        end
                    end
                end

                ST_FIN:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg                <= 1'b1;
                        rsp_data_reg.fire            <= fire_reg;
                        rsp_data_reg.spark_select    <= sel_reg;
                        rsp_data_reg.rps             <= rps_reg;
                        rsp_data_reg.rpm             <= sync_reg ? last_rpm_reg : 16'd0;
                        rsp_data_reg.pwm_frequency   <= pwm_reg;
                        rsp_data_reg.advance_value   <= adv_reg;
                        rsp_data_reg.synced          <= sync_reg;
                        state_reg                    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

// ===== rtl/cssc_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cssc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        fire,
    input logic        synced,
    input logic [23:0] rps,
    input logic [15:0] rpm,
    input logic [27:0] pwm_frequency,
    input logic [7:0]  advance_value
);

    // stalled result holds
    `CSSC_ASSERT_NXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rps) && $stable(rpm))
    // a spark needs sync
    `CSSC_ASSERT_IMP(a_fire_synced, rsp_valid && fire, synced)
    // no spark, no schedule payload
    `CSSC_ASSERT_IMP(a_idle_payload, rsp_valid && !fire, pwm_frequency == 28'd0 && advance_value == 8'd0)
    // rpm hidden while unsynced
    `CSSC_ASSERT_IMP(a_rpm_unsynced, rsp_valid && !synced, rpm == 16'd0)

endmodule

bind crank_sync_spark_scheduler cssc_chk u_cssc_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .fire          (rsp.data.fire),
    .synced        (rsp.data.synced),
    .rps           (rsp.data.rps),
    .rpm           (rsp.data.rpm),
    .pwm_frequency (rsp.data.pwm_frequency),
    .advance_value (rsp.data.advance_value)
);
